@@ src/srg_pkg.sv @@
// ----------------------------------------------------------------------------
// srg_pkg
// Shared widths, operation codes, register indexes and types for the stepper
// ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  // Velocity format: signed Q3.VEL_FRAC_BITS
  localparam int VEL_FRAC_BITS = 16;
  localparam int VEL_W         = VEL_FRAC_BITS + 4;
  localparam int CFG_W         = 16;
  localparam int STEP_W        = 31;
  localparam int HS_W          = STEP_W + 3;
  localparam int POS_WIDTH     = 48;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 2;

  // Serial unit widths
  localparam int DIV_W = CFG_W + VEL_FRAC_BITS;
  localparam int K_W   = HS_W + 2;
  localparam int ACC_W = K_W + CFG_W + 1;
  localparam int VN_W  = ACC_W + 2;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOL  = 2'd3;

  localparam logic [CFG_W-1:0] MIN_PERIOD_RST = 16'd15000;
  localparam logic [CFG_W-1:0] MAX_PERIOD_RST = 16'd10000;
  localparam logic [CFG_W-1:0] RAMP_RATE_RST  = 16'd262;
  localparam logic [CFG_W-1:0] SPEED_TOL_RST  = 16'd6554;

  typedef struct packed {
    logic start;
    logic mul;
  } srg_cmd_t;

endpackage

@@ src/srg_if.sv @@
// ----------------------------------------------------------------------------
// srg_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface srg_in_if;
  import srg_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             op;
  logic signed [VEL_W-1:0]     goal_speed;
  logic [STEP_W-1:0]           step_count;

  modport source (output valid, output op, output goal_speed, output step_count,
                  input ready);
  modport sink   (input valid, input op, input goal_speed, input step_count,
                  output ready);
endinterface

interface srg_out_if;
  import srg_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        step_level;
  logic                        dir_level;
  logic [CFG_W-1:0]            tick_period;
  logic                        period_changed;
  logic                        moving;
  logic                        move_done;
  logic signed [POS_WIDTH-1:0] position;

  modport source (output valid, output step_level, output dir_level,
                  output tick_period, output period_changed, output moving,
                  output move_done, output position, input ready);
  modport sink   (input valid, input step_level, input dir_level,
                  input tick_period, input period_changed, input moving,
                  input move_done, input position, output ready);
endinterface

@@ src/srg_serial_unit.sv @@
// ----------------------------------------------------------------------------
// srg_serial_unit
// Shared shift-and-add unit: restoring divide (one quotient bit a cycle) or
// signed-by-unsigned multiply (one multiplier bit a cycle) on one adder.
// ----------------------------------------------------------------------------
module srg_serial_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srg_pkg::srg_cmd_t                 cmd,
  input  logic [srg_pkg::DIV_W-1:0]         dividend,
  input  logic [srg_pkg::VEL_W-1:0]         divisor,
  input  logic signed [srg_pkg::K_W-1:0]    mcand,
  input  logic [srg_pkg::CFG_W-1:0]         mplier,
  output logic                              done,
  output logic [srg_pkg::DIV_W-1:0]         quot,
  output logic signed [srg_pkg::ACC_W-1:0]  prod
);
  import srg_pkg::*;

  logic                    busy_r;
  logic                    mul_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [DIV_W-1:0]        q_r;
  logic [VEL_W-1:0]        rem_r;
  logic [VEL_W-1:0]        dvs_r;
  logic signed [K_W-1:0]   mc_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [VEL_W:0]          shifted;
  logic [ACC_W-1:0]        opa;
  logic [ACC_W-1:0]        opb;
  logic                    cin;
  logic [ACC_W-1:0]        sum;

  // one adder serves both operations
  always_comb begin
    shifted = {rem_r, q_r[DIV_W-1]};
    if (mul_r) begin
      opa = {acc_r[ACC_W-2:0], 1'b0};
      opb = q_r[DIV_W-1] ? {{(ACC_W-K_W){mc_r[K_W-1]}}, mc_r} : '0;
      cin = 1'b0;
    end else begin
      opa = {{(ACC_W-VEL_W-1){1'b0}}, shifted};
      opb = ~{{(ACC_W-VEL_W){1'b0}}, dvs_r};
      cin = 1'b1;
    end
    sum = opa + opb + {{(ACC_W-1){1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mul_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        mul_r  <= cmd.mul;
        cnt_r  <= cmd.mul ? CNT_W'(CFG_W) : CNT_W'(DIV_W);
        q_r    <= cmd.mul ? {mplier, {(DIV_W-CFG_W){1'b0}}} : dividend;
        rem_r  <= '0;
        acc_r  <= '0;
        dvs_r  <= divisor;
        mc_r   <= mcand;
      end else if (busy_r) begin
        if (mul_r) begin
          acc_r <= $signed(sum);
          q_r   <= {q_r[DIV_W-2:0], 1'b0};
        end else begin
          // keep the trial difference when it did not borrow
          rem_r <= sum[ACC_W-1] ? shifted[VEL_W-1:0] : sum[VEL_W-1:0];
          q_r   <= {q_r[DIV_W-2:0], ~sum[ACC_W-1]};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign prod = acc_r;

endmodule

@@ src/stepper_ramp_generator.sv @@
// Sequence: S_IDLE accepts an item and S_EVAL decodes it. A start with a window division
// runs S_WDIV; a running tick runs S_MUL for the multiply inside the deceleration window,
// S_PER for the period step when the velocity changes, S_PDIV for the period division
// when the velocity is nonzero, and S_STEP. Other items go straight to S_OUT, which
// registers the result. Throughput: one item at a time; the next is taken back in S_IDLE.
// Reset: synchronous active-low; registers to defaults, motion state cleared.
// ----------------------------------------------------------------------------
// stepper_ramp_generator
// Trapezoidal ramp generator for a stepper drive: takes start, tick and stop
// items and returns step/direction levels, tick period and position per item.
// ----------------------------------------------------------------------------
module stepper_ramp_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  srg_in_if.sink                        in_ch,
  srg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [srg_pkg::CFG_W-1:0]     cfg_wdata
);
  import srg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_WDIV, S_MUL, S_PER, S_PDIV, S_STEP, S_OUT
  } state_t;

  // configuration registers
  logic [CFG_W-1:0] min_period_r, max_period_r, rate_r, tol_r;

  // sequencer and latched item
  state_t                  state_r;
  logic [OP_W-1:0]         op_r;
  logic signed [VEL_W-1:0] spd_r;
  logic [STEP_W-1:0]       steps_r;

  // motion state
  logic signed [VEL_W-1:0]     vel_r;
  logic signed [VEL_W-1:0]     tgt_r;
  logic signed [HS_W-1:0]      cnt_r;
  logic signed [HS_W-1:0]      goal_r;
  logic [VEL_W-1:0]            win_r;
  logic                        run_r;
  logic [POS_WIDTH-1:0]        pos_r;
  logic [CFG_W-1:0]            period_r;

  // per-item flags
  logic step_f_r, dir_f_r, changed_f_r, done_f_r;

  // result register
  logic                 out_valid_r;
  logic                 o_step_r, o_dir_r, o_changed_r, o_moving_r, o_done_r;
  logic [CFG_W-1:0]     o_period_r;
  logic [POS_WIDTH-1:0] o_pos_r;

  // serial unit hookup
  srg_cmd_t                unit_cmd;
  logic [DIV_W-1:0]        unit_dividend;
  logic [VEL_W-1:0]        unit_divisor;
  logic signed [K_W-1:0]   unit_mcand;
  logic                    unit_done;
  logic [DIV_W-1:0]        unit_quot;
  logic signed [ACC_W-1:0] unit_prod;

  // helpers
  logic                    vel_pos, tgt_pos, spd_pos;
  logic [VEL_W:0]          spd_abs, tgt_abs, vel_abs;
  logic signed [VEL_W+1:0] win_diff;
  logic                    win_need_div;
  logic [HS_W-1:0]         goal_mag;
  logic signed [HS_W:0]    gc_diff;
  logic [HS_W:0]           remaining, cnt_abs, goal_abs;
  logic                    in_decel;
  logic signed [K_W-1:0]   k_val;
  logic signed [VEL_W:0]   tv_diff;
  logic [VEL_W:0]          tv_abs;
  logic                    ramp_need;
  logic signed [VN_W-1:0]  vn_decel, vn_ramp, mag_decel;
  logic signed [HS_W-1:0]  cnt_step;
  logic                    start_ok;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VN_W-1:0] x);
    logic [VN_W-VEL_W:0] hi;
    hi = x[VN_W-1:VEL_W-1];
    if ((&hi) || !(|hi)) begin
      sat_vel = x[VEL_W-1:0];
    end else begin
      sat_vel = x[VN_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

  // cap at max_period, then floor at 1
  function automatic logic [CFG_W-1:0] limit_period(input logic [DIV_W-1:0] p,
                                                    input logic [CFG_W-1:0] pmax);
    logic [CFG_W-1:0] c;
    c = (p > DIV_W'(pmax)) ? pmax : p[CFG_W-1:0];
    limit_period = (c == '0) ? CFG_W'(1) : c;
  endfunction

  always_comb begin
    vel_pos = !vel_r[VEL_W-1] && (vel_r != '0);
    tgt_pos = !tgt_r[VEL_W-1] && (tgt_r != '0);
    spd_pos = !spd_r[VEL_W-1] && (spd_r != '0);
    spd_abs = spd_r[VEL_W-1] ? ((VEL_W+1)'(0) - {spd_r[VEL_W-1], spd_r}) : {1'b0, spd_r};
    tgt_abs = tgt_r[VEL_W-1] ? ((VEL_W+1)'(0) - {tgt_r[VEL_W-1], tgt_r}) : {1'b0, tgt_r};
    vel_abs = vel_r[VEL_W-1] ? ((VEL_W+1)'(0) - {vel_r[VEL_W-1], vel_r}) : {1'b0, vel_r};
    start_ok = (spd_r != '0) && (steps_r != '0);
    goal_mag = HS_W'({steps_r, 1'b0});

    // deceleration window: (|speed| - tolerance) / rate
    win_diff     = $signed({1'b0, spd_abs}) - $signed({2'b00, tol_r});
    win_need_div = !win_diff[VEL_W+1] && (win_diff != '0);

    // half-steps left and window test
    gc_diff   = $signed({goal_r[HS_W-1], goal_r}) - $signed({cnt_r[HS_W-1], cnt_r});
    remaining = gc_diff[HS_W] ? ((HS_W+1)'(0) - gc_diff) : gc_diff;
    in_decel  = remaining <= (HS_W+1)'(win_r);
    cnt_abs   = cnt_r[HS_W-1] ? ((HS_W+1)'(0) - {cnt_r[HS_W-1], cnt_r})
                              : {1'b0, cnt_r};
    goal_abs  = goal_r[HS_W-1] ? ((HS_W+1)'(0) - {goal_r[HS_W-1], goal_r})
                               : {1'b0, goal_r};
    k_val     = $signed({1'b0, cnt_abs}) - $signed({1'b0, goal_abs})
              + $signed({{(K_W-VEL_W){1'b0}}, win_r});

    // ramp test toward target
    tv_diff   = $signed({tgt_r[VEL_W-1], tgt_r}) - $signed({vel_r[VEL_W-1], vel_r});
    tv_abs    = tv_diff[VEL_W] ? ((VEL_W+1)'(0) - tv_diff) : tv_diff;
    ramp_need = tv_abs > (VEL_W+1)'(tol_r);
    vn_ramp   = (!tv_diff[VEL_W])
              ? (VN_W'(vel_r) + $signed({{(VN_W-CFG_W){1'b0}}, rate_r}))
              : (VN_W'(vel_r) - $signed({{(VN_W-CFG_W){1'b0}}, rate_r}));

    // linear fall inside the window
    mag_decel = $signed({{(VN_W-VEL_W-1){1'b0}}, tgt_abs}) - VN_W'(unit_prod);
    vn_decel  = tgt_pos ? mag_decel : -mag_decel;

    cnt_step  = vel_pos ? (cnt_r + HS_W'(1)) : (cnt_r - HS_W'(1));
  end

  // serial unit commands
  always_comb begin
    unit_cmd      = '0;
    unit_dividend = {{(DIV_W-VEL_W-1){1'b0}}, win_diff[VEL_W:0]};
    unit_divisor  = VEL_W'(rate_r);
    unit_mcand    = k_val;
    case (state_r)
      S_EVAL: begin
        if (op_r == OP_START && start_ok && rate_r != '0 && win_need_div) begin
          unit_cmd.start = 1'b1;
        end else if (op_r == OP_TICK && run_r && in_decel) begin
          unit_cmd.start = 1'b1;
          unit_cmd.mul   = 1'b1;
        end
      end
      S_PER: begin
        unit_dividend = {min_period_r, {VEL_FRAC_BITS{1'b0}}};
        unit_divisor  = vel_abs[VEL_W-1:0];
        unit_cmd.start = (vel_r != '0);
      end
      default: begin
        unit_cmd = '0;
      end
    endcase
  end

  srg_serial_unit u_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (unit_cmd),
    .dividend (unit_dividend),
    .divisor  (unit_divisor),
    .mcand    (unit_mcand),
    .mplier   (rate_r),
    .done     (unit_done),
    .quot     (unit_quot),
    .prod     (unit_prod)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RST;
      max_period_r <= MAX_PERIOD_RST;
      rate_r       <= RAMP_RATE_RST;
      tol_r        <= SPEED_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_PERIOD: min_period_r <= cfg_wdata;
        CFG_MAX_PERIOD: max_period_r <= cfg_wdata;
        CFG_RAMP_RATE:  rate_r       <= cfg_wdata;
        CFG_SPEED_TOL:  tol_r        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer, motion state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vel_r       <= '0;
      tgt_r       <= '0;
      cnt_r       <= '0;
      goal_r      <= '0;
      win_r       <= '0;
      run_r       <= 1'b0;
      pos_r       <= '0;
      period_r    <= MIN_PERIOD_RST;
      out_valid_r <= 1'b0;
      step_f_r    <= 1'b0;
      dir_f_r     <= 1'b0;
      changed_f_r <= 1'b0;
      done_f_r    <= 1'b0;
    end else begin
      // drop the result once taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r        <= in_ch.op;
            spd_r       <= in_ch.goal_speed;
            steps_r     <= in_ch.step_count;
            step_f_r    <= 1'b0;
            dir_f_r     <= 1'b0;
            changed_f_r <= 1'b0;
            done_f_r    <= 1'b0;
            state_r     <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_OUT;
          case (op_r)
            OP_START: begin
              if (start_ok) begin
                goal_r <= spd_pos ? $signed(goal_mag) : $signed(HS_W'(0) - goal_mag);
                cnt_r  <= '0;
                tgt_r  <= spd_r;
                run_r  <= 1'b1;
                if (rate_r == '0) begin
                  win_r <= '1;
                end else if (win_need_div) begin
                  state_r <= S_WDIV;
                end else begin
                  win_r <= '0;
                end
              end
            end
            OP_STOP: begin
              run_r    <= 1'b0;
              cnt_r    <= '0;
              vel_r    <= '0;
              done_f_r <= 1'b1;
            end
            OP_TICK: begin
              if (run_r) begin
                if (in_decel) begin
                  state_r <= S_MUL;
                end else if (ramp_need) begin
                  vel_r   <= sat_vel(vn_ramp);
                  state_r <= S_PER;
                end else begin
                  state_r <= S_STEP;
                end
              end
            end
            default: begin
              state_r <= S_OUT;
            end
          endcase
        end
        S_WDIV: begin
          if (unit_done) begin
            win_r   <= unit_quot[VEL_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_MUL: begin
          if (unit_done) begin
            vel_r   <= sat_vel(vn_decel);
            state_r <= S_PER;
          end
        end
        S_PER: begin
          changed_f_r <= 1'b1;
          if (vel_r == '0) begin
            period_r <= limit_period(DIV_W'(max_period_r), max_period_r);
            state_r  <= S_STEP;
          end else begin
            state_r  <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (unit_done) begin
            period_r <= limit_period(unit_quot, max_period_r);
            state_r  <= S_STEP;
          end
        end
        S_STEP: begin
          // levels reflect the count before the advance
          step_f_r <= ~cnt_r[0];
          dir_f_r  <= vel_pos;
          pos_r    <= vel_pos ? (pos_r + POS_WIDTH'(1)) : (pos_r - POS_WIDTH'(1));
          if (cnt_step == goal_r) begin
            cnt_r       <= '0;
            vel_r       <= '0;
            run_r       <= 1'b0;
            period_r    <= limit_period(DIV_W'(min_period_r), max_period_r);
            changed_f_r <= 1'b1;
            done_f_r    <= 1'b1;
          end else begin
            cnt_r <= cnt_step;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_step_r    <= step_f_r;
            o_dir_r     <= dir_f_r;
            o_period_r  <= period_r;
            o_changed_r <= changed_f_r;
            o_moving_r  <= run_r;
            o_done_r    <= done_f_r;
            o_pos_r     <= pos_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.step_level     = o_step_r;
  assign out_ch.dir_level      = o_dir_r;
  assign out_ch.tick_period    = o_period_r;
  assign out_ch.period_changed = o_changed_r;
  assign out_ch.moving         = o_moving_r;
  assign out_ch.move_done      = o_done_r;
  assign out_ch.position       = $signed(o_pos_r);

endmodule
